// ----- rtl/core/sqvg_pkg.sv -----
// Shared types, constants and the quarter-wave sine table builder for the
// sprite quad vertex generator. No dependencies.
package sqvg_pkg;

  localparam int SIN_DEPTH = 1024;
  localparam int SIN_AW    = $clog2(SIN_DEPTH);
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  typedef logic [16:0] sin_mag_t;
  typedef sin_mag_t sin_rom_t [0:SIN_DEPTH];

  // Corners and per-sprite data handed from front to back
  typedef struct packed {
    logic signed [24:0] xa;   // -cx
    logic signed [24:0] xb;   // width - cx
    logic signed [24:0] ya;   // -cy
    logic signed [24:0] yb;   // height - cy
    logic signed [16:0] sn;
    logic signed [16:0] cs;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic [15:0]        u1;
    logic [15:0]        u2;
    logic [15:0]        v1;
    logic [15:0]        v2;
    logic [31:0]        tint;
  } sprite_t;

  // Q30 Taylor series, rounded to Q1.15
  function automatic sin_rom_t build_sin_rom();
    sin_rom_t    rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] q;
    for (int k = 0; k <= SIN_DEPTH; k++) begin
      x    = (PI_HALF_Q30 * 64'(k)) / 64'(SIN_DEPTH);
      x2   = (x * x) >> 30;
      sum  = x;
      term = x;
      for (int n = 1; n <= 12; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      q = (sum + 64'd16384) >> 15;
      if (q > 64'd32768) begin
        q = 64'd32768;
      end
      rom[k] = q[16:0];
    end
    return rom;
  endfunction

endpackage

// ----- rtl/core/sqvg_front.sv -----
// Front end: accepts a sprite, computes pivot offsets and looks up sine/cosine.
// Depends on sqvg_pkg.
module sqvg_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [241:0]     in_data,
  output logic             push,
  input  logic             full,
  output sqvg_pkg::sprite_t push_data
);

  localparam int AW = sqvg_pkg::SIN_AW;
  localparam sqvg_pkg::sin_rom_t SIN_ROM = sqvg_pkg::build_sin_rom();

  logic [22:0]  in_w;
  logic [22:0]  in_h;
  logic [16:0]  in_ox;
  logic [16:0]  in_oy;
  logic [15:0]  in_ang;
  logic [1:0]   in_flip;
  logic [AW+17:0] ph_prod;
  logic [AW+1:0]  phase;
  logic [1:0]   quad;
  logic [1:0]   cquad;
  logic [AW-1:0] off;
  logic [AW:0]  sin_idx;
  logic [AW:0]  cos_idx;
  logic [39:0]  cx_prod;
  logic [39:0]  cy_prod;

  logic         valid;
  logic [23:0]  cx;
  logic [23:0]  cy;
  logic [22:0]  w;
  logic [22:0]  h;
  sqvg_pkg::sin_mag_t sin_mag;
  sqvg_pkg::sin_mag_t cos_mag;
  logic         sin_neg;
  logic         cos_neg;
  logic [23:0]  px;
  logic [23:0]  py;
  logic [15:0]  u1;
  logic [15:0]  u2;
  logic [15:0]  v1;
  logic [15:0]  v2;
  logic [31:0]  tint;

  assign in_w    = in_data[70:48];
  assign in_h    = in_data[93:71];
  assign in_ox   = in_data[110:94];
  assign in_oy   = in_data[127:111];
  assign in_ang  = in_data[143:128];
  assign in_flip = in_data[209:208];

  assign ph_prod = (AW + 18)'(in_ang) * (AW + 18)'(4 * sqvg_pkg::SIN_DEPTH);
  assign phase   = ph_prod[AW+17:16];
  assign quad    = phase[AW+1:AW];
  assign cquad   = quad + 2'd1;
  assign off     = phase[AW-1:0];
  assign sin_idx = quad[0]  ? ((AW + 1)'(sqvg_pkg::SIN_DEPTH) - {1'b0, off}) : {1'b0, off};
  assign cos_idx = cquad[0] ? ((AW + 1)'(sqvg_pkg::SIN_DEPTH) - {1'b0, off}) : {1'b0, off};

  assign cx_prod = 40'(in_w) * 40'(in_ox);
  assign cy_prod = 40'(in_h) * 40'(in_oy);

  assign push     = valid && !full;
  assign in_ready = !valid || push;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cx      <= cx_prod[39:16];
      cy      <= cy_prod[39:16];
      w       <= in_w;
      h       <= in_h;
      sin_mag <= SIN_ROM[sin_idx];
      cos_mag <= SIN_ROM[cos_idx];
      sin_neg <= quad[1];
      cos_neg <= cquad[1];
      px      <= in_data[23:0];
      py      <= in_data[47:24];
      u1      <= in_flip[0] ? in_data[175:160] : in_data[159:144];
      u2      <= in_flip[0] ? in_data[159:144] : in_data[175:160];
      v1      <= in_flip[1] ? in_data[207:192] : in_data[191:176];
      v2      <= in_flip[1] ? in_data[191:176] : in_data[207:192];
      tint    <= in_data[241:210];
    end
  end

  always_comb begin
    push_data.xa   = -$signed({1'b0, cx});
    push_data.xb   = $signed({2'b00, w}) - $signed({1'b0, cx});
    push_data.ya   = -$signed({1'b0, cy});
    push_data.yb   = $signed({2'b00, h}) - $signed({1'b0, cy});
    push_data.sn   = sin_neg ? -$signed(sin_mag) : $signed(sin_mag);
    push_data.cs   = cos_neg ? -$signed(cos_mag) : $signed(cos_mag);
    push_data.px   = $signed(px);
    push_data.py   = $signed(py);
    push_data.u1   = u1;
    push_data.u2   = u2;
    push_data.v1   = v1;
    push_data.v2   = v2;
    push_data.tint = tint;
  end

endmodule

// ----- rtl/core/sqvg_queue.sv -----
// Two-entry queue of set-up sprites between front and back.
// Depends on sqvg_pkg.
module sqvg_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sqvg_pkg::sprite_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output sqvg_pkg::sprite_t head
);

  sqvg_pkg::sprite_t mem [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- rtl/core/sqvg_back.sv -----
// Back end: rotates corners and emits six vertices per sprite.
// Depends on sqvg_pkg.
module sqvg_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              not_empty,
  input  sqvg_pkg::sprite_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [119:0]      out_data,
  output logic              out_last
);

  function automatic logic [1:0] slot_corner(input logic [2:0] slot);
    logic [1:0] k;
    case (slot)
      3'd0, 3'd3: k = 2'd0;
      3'd1:       k = 2'd1;
      3'd2, 3'd4: k = 2'd2;
      default:    k = 2'd3;
    endcase
    return k;
  endfunction

  logic        adv;
  logic        issue;
  logic [2:0]  cnt;
  logic [1:0]  k;
  logic signed [24:0] cx_in;
  logic signed [24:0] cy_in;

  // stage 1: products
  logic        v1;
  logic [2:0]  slot1;
  logic signed [41:0] p_cx;
  logic signed [41:0] p_sy;
  logic signed [41:0] p_sx;
  logic signed [41:0] p_cy;
  logic signed [23:0] px1;
  logic signed [23:0] py1;
  logic [15:0] u1s;
  logic [15:0] v1s;
  logic [31:0] tint1;

  // stage 2: rotated offsets
  logic signed [42:0] rx_full;
  logic signed [42:0] ry_full;
  logic signed [26:0] rx;
  logic signed [26:0] ry;
  logic signed [26:0] sx [0:2];
  logic signed [26:0] sy [0:2];
  logic signed [27:0] dx_next;
  logic signed [27:0] dy_next;
  logic        v2;
  logic [2:0]  slot2;
  logic signed [27:0] dx;
  logic signed [27:0] dy;
  logic signed [23:0] px2;
  logic signed [23:0] py2;
  logic [15:0] u2s;
  logic [15:0] v2s;
  logic [31:0] tint2;

  // stage 3: output register
  logic signed [28:0] fx;
  logic signed [28:0] fy;
  logic        ov;
  logic [2:0]  oslot;
  logic [23:0] ox;
  logic [23:0] oy;
  logic [15:0] ou;
  logic [15:0] ovv;
  logic [31:0] ocol;

  assign adv   = !ov || out_ready;
  assign issue = adv && not_empty;
  assign pop   = issue && cnt == 3'd5;
  assign k     = slot_corner(cnt);
  assign cx_in = k[1] ? head.xb : head.xa;
  assign cy_in = (k == 2'd0 || k == 2'd3) ? head.ya : head.yb;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
      v1  <= 1'b0;
      v2  <= 1'b0;
      ov  <= 1'b0;
    end else if (adv) begin
      v1 <= not_empty;
      v2 <= v1;
      ov <= v2;
      if (issue) begin
        cnt <= (cnt == 3'd5) ? 3'd0 : cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      slot1 <= cnt;
      p_cx  <= 42'(head.cs * cx_in);
      p_sy  <= 42'(head.sn * cy_in);
      p_sx  <= 42'(head.sn * cx_in);
      p_cy  <= 42'(head.cs * cy_in);
      px1   <= head.px;
      py1   <= head.py;
      u1s   <= k[1] ? head.u2 : head.u1;
      v1s   <= (k == 2'd0 || k == 2'd3) ? head.v1 : head.v2;
      tint1 <= head.tint;
    end
  end

  assign rx_full = 43'(p_cx) - 43'(p_sy);
  assign ry_full = 43'(p_sx) + 43'(p_cy);
  assign rx = rx_full[41:15];   // floor via arithmetic truncation
  assign ry = ry_full[41:15];

  always_comb begin
    case (slot1)
      3'd3: begin
        dx_next = 28'(sx[0]);
        dy_next = 28'(sy[0]);
      end
      3'd4: begin
        dx_next = 28'(sx[2]);
        dy_next = 28'(sy[2]);
      end
      3'd5: begin
        // fourth corner = c1 + c3 - c2
        dx_next = 28'(sx[0]) + 28'(sx[2]) - 28'(sx[1]);
        dy_next = 28'(sy[0]) + 28'(sy[2]) - 28'(sy[1]);
      end
      default: begin
        dx_next = 28'(rx);
        dy_next = 28'(ry);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (v1 && slot1 < 3'd3) begin
        sx[slot1[1:0]] <= rx;
        sy[slot1[1:0]] <= ry;
      end
      slot2 <= slot1;
      dx    <= dx_next;
      dy    <= dy_next;
      px2   <= px1;
      py2   <= py1;
      u2s   <= u1s;
      v2s   <= v1s;
      tint2 <= tint1;
    end
  end

  assign fx = 29'(dx) + 29'(px2);
  assign fy = 29'(dy) + 29'(py2);

  always_ff @(posedge clk) begin
    if (adv) begin
      oslot <= slot2;
      ox    <= (fx > 29'sd8388607) ? 24'h7FFFFF :
               (fx < -29'sd8388608) ? 24'h800000 : fx[23:0];
      oy    <= (fy > 29'sd8388607) ? 24'h7FFFFF :
               (fy < -29'sd8388608) ? 24'h800000 : fy[23:0];
      ou    <= u2s;
      ovv   <= v2s;
      ocol  <= tint2;
    end
  end

  assign out_valid = ov;
  assign out_last  = oslot == 3'd5;
  assign out_data  = {5'd0, oslot, ocol, ovv, ou, oy, ox};

endmodule

// ----- rtl/core/sprite_quad_vertex_generator.sv -----
// Sprite quad vertex generator: one sprite in, six vertices out.
// Throughput: the back end emits one vertex per cycle while m_tready
// is held high; the front end takes a new sprite while the back works.
// Reset: synchronous active-high rst empties the pipeline and queue.
module sprite_quad_vertex_generator (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x, pos_y, width, height, origin_x, origin_y, angle, u_pair, v_pair,
  // flip_bits, tint_rgba, zero fill
  input  logic [247:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // vert_x, vert_y, vert_u, vert_v, vert_color, corner_slot, zero fill
  output logic [119:0] m_tdata,
  output logic         m_tlast
);

  logic              push;
  logic              full;
  logic              pop;
  logic              not_empty;
  sqvg_pkg::sprite_t push_data;
  sqvg_pkg::sprite_t head;

  sqvg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata[241:0]),
    .push      (push),
    .full      (full),
    .push_data (push_data)
  );

  sqvg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  sqvg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
